// ===== design/dq_pkg.sv =====
// Shared types, constants and helpers for the double-ended queue.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package dq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW1   = AW + 1;
  localparam int DW    = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic          en;
    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] wdata;
  } ram_cmd_t;

  // ring position base + off, both below DEPTH
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= AW1'(DEPTH)) begin
      sum = sum - AW1'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dq_if.sv =====
// Request and response channel interfaces of the double-ended queue.
// Depends on dq_pkg for the data width.
`default_nettype none

interface dq_req_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             func;
  logic signed [dq_pkg::DW-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dq_rsp_if;
  logic                   valid;
  logic                   ready;
  logic signed [dq_pkg::DW-1:0] result_value;
  logic [1:0]             status;
  logic                   last;

  modport source (output valid, output result_value, output status, output last, input ready);
  modport sink   (input valid, input result_value, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== design/dq_ram.sv =====
// Single-port element store with registered read data.
// Depends on dq_pkg for depth, widths and the command struct.
`default_nettype none

module dq_ram (
  input  wire logic               clk,
  input  wire dq_pkg::ram_cmd_t   cmd,
  output logic [dq_pkg::DW-1:0]   rdata
);

  logic [dq_pkg::DW-1:0] mem [dq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[cmd.addr] <= cmd.wdata;
      end else begin
        rdata <= mem[cmd.addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dq_ctrl.sv =====
// Sequencer of the double-ended queue: head and count, store commands, result register.
// Depends on dq_pkg and the channel interfaces in dq_if.sv.
`default_nettype none

module dq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  dq_req_if.sink                 req,
  dq_rsp_if.source               rsp,
  output dq_pkg::ram_cmd_t       ram_cmd,
  input  wire logic [dq_pkg::DW-1:0] ram_rdata
);

  dq_pkg::state_t          state, state_next;
  logic [dq_pkg::AW-1:0]   head, head_next;
  logic [dq_pkg::CW-1:0]   count, count_next;
  logic [dq_pkg::AW-1:0]   idx, idx_next;

  logic                    out_valid;
  logic [dq_pkg::DW-1:0]   out_value;
  logic [1:0]              out_status;
  logic                    out_last;

  logic                    load;
  logic [dq_pkg::DW-1:0]   ld_value;
  logic [1:0]              ld_status;
  logic                    ld_last;

  logic                    accept;
  logic                    out_free;
  logic                    is_empty;
  logic                    is_full;
  logic                    dump_last;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == dq_pkg::S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == dq_pkg::CW'(dq_pkg::DEPTH));
  assign dump_last = (({1'b0, idx} + dq_pkg::AW1'(1)) == dq_pkg::AW1'(count));

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.last         = out_last;

  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (accept && !is_empty) begin
          if (req.func == dq_pkg::OP_POP_FRONT || req.func == dq_pkg::OP_POP_BACK) begin
            state_next = dq_pkg::S_POP;
          end else if (req.func == dq_pkg::OP_DUMP) begin
            state_next = dq_pkg::S_DUMP;
          end
        end
      end
      dq_pkg::S_POP: begin
        state_next = dq_pkg::S_IDLE;
      end
      dq_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    ram_cmd    = '0;
    load       = 1'b0;
    ld_value   = '0;
    ld_status  = dq_pkg::ST_OK;
    ld_last    = 1'b1;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (accept) begin
          case (req.func)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = dq_pkg::ST_FULL;
              end else begin
                ram_cmd.en    = 1'b1;
                ram_cmd.we    = 1'b1;
                ram_cmd.wdata = req.value;
                count_next    = count + dq_pkg::CW'(1);
                if (req.func == dq_pkg::OP_PUSH_FRONT) begin
                  head_next = (head == '0) ? dq_pkg::AW'(dq_pkg::DEPTH - 1)
                                           : head - dq_pkg::AW'(1);
                  ram_cmd.addr = head_next;
                end else begin
                  ram_cmd.addr = dq_pkg::wrap(head, count[dq_pkg::AW-1:0]);
                end
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = dq_pkg::ST_EMPTY;
              end else begin
                ram_cmd.en = 1'b1;
                count_next = count - dq_pkg::CW'(1);
                if (req.func == dq_pkg::OP_POP_FRONT) begin
                  ram_cmd.addr = head;
                  head_next    = dq_pkg::wrap(head, dq_pkg::AW'(1));
                end else begin
                  ram_cmd.addr = dq_pkg::wrap(head, count_next[dq_pkg::AW-1:0]);
                end
              end
            end
            dq_pkg::OP_CLEAR: begin
              load       = 1'b1;
              ld_status  = is_empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
              head_next  = '0;
              count_next = '0;
            end
            dq_pkg::OP_DUMP: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = dq_pkg::ST_EMPTY;
              end else begin
                ram_cmd.en   = 1'b1;
                ram_cmd.addr = head;
                idx_next     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dq_pkg::S_POP: begin
        load     = 1'b1;
        ld_value = ram_rdata;
      end
      dq_pkg::S_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          ld_value = ram_rdata;
          ld_last  = dump_last;
          if (!dump_last) begin
            idx_next     = idx + dq_pkg::AW'(1);
            ram_cmd.en   = 1'b1;
            ram_cmd.addr = dq_pkg::wrap(head, idx_next);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dq_pkg::S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load) begin
      out_value  <= ld_value;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::CW'(dq_pkg::DEPTH))
    else $error("element count above depth");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == dq_pkg::S_POP |-> !out_valid)
    else $error("pop result would overwrite a pending response");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == dq_pkg::OP_PUSH_FRONT || req.func == dq_pkg::OP_PUSH_BACK)
      && !is_full |=> count == $past(count) + dq_pkg::CW'(1))
    else $error("push did not advance the count");

  a_dump_index: assert property (@(posedge clk) disable iff (rst)
    state == dq_pkg::S_DUMP |-> dq_pkg::AW1'(idx) < dq_pkg::AW1'(count))
    else $error("dump index past the held range");

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values on a ring-buffer element store.
// Push and pop at either end, clear, and a front-to-back dump of the content. A push,
// a clear, a failed pop and an empty dump load the response register on acceptance; an
// unused code is accepted and gives no response. A popped element is first read from
// the single-port store, then loaded into the response register. A dump gives one
// result a cycle while the sink takes them, paced by the store read that feeds each
// result. Requests are taken when the sequencer is idle and the response register is
// free or being drained. The store needs no clearing pass after reset; only entries
// inside the held range are read. Depends on dq_pkg, dq_if.sv, dq_ram and dq_ctrl.
`default_nettype none

module double_ended_queue (
  input  wire logic clk,
  input  wire logic rst,
  dq_req_if.sink    req,
  dq_rsp_if.source  rsp
);

  dq_pkg::ram_cmd_t      ram_cmd;
  logic [dq_pkg::DW-1:0] ram_rdata;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .ram_cmd   (ram_cmd),
    .ram_rdata (ram_rdata)
  );

  dq_ram u_ram (
    .clk   (clk),
    .cmd   (ram_cmd),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== test/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed and random requests, each checked
// against an in-bench deque predictor, with sender gaps and receiver stalls in several phases.
// Depends on dq_pkg, dq_if.sv and the double_ended_queue RTL.

module tb_double_ended_queue;

  localparam logic [2:0] OP_RESERVED_A = 3'd6;
  localparam logic [2:0] OP_RESERVED_B = 3'd7;
  localparam int CLK_HALF_NS = 6;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic signed [dq_pkg::DW-1:0] result_value;
    logic [1:0]                   status;
    logic                         last;
  } deque_result_t;

  logic clk;
  logic rst;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [dq_pkg::DW-1:0] shadow_store [dq_pkg::DEPTH];
  logic [dq_pkg::AW-1:0]        shadow_head;
  logic [dq_pkg::CW-1:0]        shadow_count;
  deque_result_t                pending_results [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  always #(CLK_HALF_NS) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL double_ended_queue");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  function automatic logic [dq_pkg::AW-1:0] ring_slot(input int off);
    return dq_pkg::AW'((int'(shadow_head) + off) % dq_pkg::DEPTH);
  endfunction

  function automatic void predict_deque_op(input logic [2:0] f,
                                           input logic signed [dq_pkg::DW-1:0] v);
    logic signed [dq_pkg::DW-1:0] taken;
    case (f)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (shadow_count == dq_pkg::CW'(dq_pkg::DEPTH)) begin
          pending_results.push_back('{result_value: '0, status: dq_pkg::ST_FULL, last: 1'b1});
        end else begin
          if (f == dq_pkg::OP_PUSH_FRONT) begin
            shadow_head = ring_slot(dq_pkg::DEPTH - 1);
            shadow_store[shadow_head] = v;
          end else begin
            shadow_store[ring_slot(int'(shadow_count))] = v;
          end
          shadow_count = shadow_count + dq_pkg::CW'(1);
          pending_results.push_back('{result_value: '0, status: dq_pkg::ST_OK, last: 1'b1});
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (shadow_count == '0) begin
          pending_results.push_back('{result_value: '0, status: dq_pkg::ST_EMPTY, last: 1'b1});
        end else begin
          if (f == dq_pkg::OP_POP_FRONT) begin
            taken = shadow_store[ring_slot(0)];
            shadow_head = ring_slot(1);
          end else begin
            taken = shadow_store[ring_slot(int'(shadow_count) - 1)];
          end
          shadow_count = shadow_count - dq_pkg::CW'(1);
          pending_results.push_back('{result_value: taken, status: dq_pkg::ST_OK, last: 1'b1});
        end
      end
      dq_pkg::OP_CLEAR: begin
        pending_results.push_back('{result_value: '0,
                                    status: (shadow_count == '0) ? dq_pkg::ST_EMPTY
                                                                 : dq_pkg::ST_OK,
                                    last: 1'b1});
        shadow_head = '0;
        shadow_count = '0;
      end
      dq_pkg::OP_DUMP: begin
        if (shadow_count == '0) begin
          pending_results.push_back('{result_value: '0, status: dq_pkg::ST_EMPTY, last: 1'b1});
        end else begin
          for (int i = 0; i < int'(shadow_count); i++) begin
            pending_results.push_back('{result_value: shadow_store[ring_slot(i)],
                                        status: dq_pkg::ST_OK,
                                        last: (i == int'(shadow_count) - 1)});
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: value %0d status %0d last %0b", $time,
                 rsp_ch.result_value, rsp_ch.status, rsp_ch.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.result_value !== want.result_value) begin
          $display("%0t result_value mismatch: expected %0d actual %0d", $time,
                   want.result_value, rsp_ch.result_value);
          mismatch_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.last !== want.last) begin
          $display("%0t last mismatch: expected %0b actual %0b", $time,
                   want.last, rsp_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [2:0] f, input logic signed [dq_pkg::DW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    predict_deque_op(f, v);
    @(negedge clk);
  endtask

  function automatic logic signed [dq_pkg::DW-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_request(dq_pkg::OP_POP_FRONT, 32'sd5);
    send_request(dq_pkg::OP_POP_BACK, -32'sd5);
    send_request(dq_pkg::OP_DUMP, '0);
    send_request(dq_pkg::OP_CLEAR, '0);
  endtask

  task automatic test_both_ends();
    send_request(dq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(dq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    send_request(dq_pkg::OP_PUSH_FRONT, -32'sd1);
    send_request(dq_pkg::OP_PUSH_BACK, '0);
    send_request(dq_pkg::OP_PUSH_BACK, 32'sh5555_AAAA);
    send_request(dq_pkg::OP_DUMP, '0);
    send_request(dq_pkg::OP_POP_BACK, '0);
    send_request(dq_pkg::OP_POP_FRONT, '0);
    send_request(dq_pkg::OP_DUMP, '0);
  endtask

  task automatic test_reserved_codes();
    send_request(OP_RESERVED_A, 32'sh1234_5678);
    send_request(OP_RESERVED_B, -32'sd1);
    send_request(dq_pkg::OP_DUMP, '0);
    send_request(dq_pkg::OP_CLEAR, '0);
    send_request(dq_pkg::OP_DUMP, '0);
  endtask

  task automatic test_full_queue();
    send_idle_pct = 23;
    rsp_stall_pct = 23;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      send_request(($urandom_range(0, 1) != 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                   random_value());
    end
    send_request(dq_pkg::OP_PUSH_FRONT, 32'sd1);
    send_request(dq_pkg::OP_PUSH_BACK, 32'sd2);
    send_request(dq_pkg::OP_DUMP, '0);
    for (int i = 0; i < dq_pkg::DEPTH / 2; i++) begin
      send_request(($urandom_range(0, 1) != 0) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                   '0);
    end
    send_request(dq_pkg::OP_DUMP, '0);
    send_request(dq_pkg::OP_CLEAR, '0);
  endtask

  task automatic test_random_mix(input int per_phase);
    int idle_by_phase [4] = '{0, 59, 0, 23};
    int stall_by_phase [4] = '{0, 0, 59, 23};
    int push_pct;
    int sent;
    int r;
    logic [2:0] f;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      rsp_stall_pct = stall_by_phase[phase];
      sent = 0;
      while (sent < per_phase) begin
        if (sent % 25 == 0) push_pct = $urandom_range(25, 80);
        r = $urandom_range(0, 99);
        if (r < 2) f = ($urandom_range(0, 1) != 0) ? OP_RESERVED_A : OP_RESERVED_B;
        else if (r < 5) f = dq_pkg::OP_CLEAR;
        else if (r < 12) f = dq_pkg::OP_DUMP;
        else if ($urandom_range(0, 99) < push_pct)
          f = ($urandom_range(0, 1) != 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
        else
          f = ($urandom_range(0, 1) != 0) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
        send_request(f, random_value());
        if (f != OP_RESERVED_A && f != OP_RESERVED_B) sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = dq_pkg::OP_PUSH_FRONT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    shadow_head = '0;
    shadow_count = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) shadow_store[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_queue();
    test_both_ends();
    test_reserved_codes();
    test_full_queue();
    test_random_mix(33);

    req_ch.valid <= 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (dq_pkg::DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule
